[hw/rtl/line_rasterizer_unit_macros.svh]
// Assertion helpers for the line rasterizer checker.
`ifndef LINE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("line_rasterizer_unit: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("line_rasterizer_unit: assertion failed");

`endif

[hw/rtl/lr_pkg.sv]
package lr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int DEC_BITS    = COORD_BITS + 4;
	localparam int PIX_BITS    = COORD_BITS + 1;
	localparam int ORIGIN_BITS = 11;
	localparam int SUM_BITS    = (PIX_BITS > ORIGIN_BITS) ? PIX_BITS : ORIGIN_BITS + 1;
	localparam int NUM_CFG     = 2;
	localparam int CFG_IDX_BITS = (NUM_CFG > 1) ? $clog2(NUM_CFG) : 1;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic signed [DIFF_BITS-1:0]   diff_t;
	typedef logic signed [DEC_BITS-1:0]    dec_t;
	typedef logic signed [PIX_BITS-1:0]    pix_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic        [ORIGIN_BITS-1:0] origin_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ORIGIN_X = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_ORIGIN_Y = cfg_idx_t'(1);

	localparam origin_t ORIGIN_X_RESET = origin_t'(320);
	localparam origin_t ORIGIN_Y_RESET = origin_t'(240);

	// Command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Walking direction of the active line
	typedef enum logic [1:0] {
		MODE_SHALLOW_POS = 2'd0,
		MODE_STEEP_POS   = 2'd1,
		MODE_STEEP_NEG   = 2'd2,
		MODE_SHALLOW_NEG = 2'd3
	} mode_t;

	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		coord_t stop;
		dec_t   decision;
		dec_t   incr_keep;
		dec_t   incr_diag;
		mode_t  mode;
	} line_state_t;

	// True when the current pixel sits on the end coordinate of the major axis
	function automatic logic at_end(input line_state_t ls);
		logic shallow;
		shallow = (ls.mode == MODE_SHALLOW_POS) || (ls.mode == MODE_SHALLOW_NEG);
		return shallow ? (ls.cur_x == ls.stop) : (ls.cur_y == ls.stop);
	endfunction

	// Offset a coordinate by the screen origin, wrapping to the pixel width
	function automatic pix_t to_screen(input coord_t c, input origin_t o);
		sum_t s;
		s = sum_t'(c) + sum_t'(o);
		return pix_t'(s);
	endfunction

endpackage

[hw/rtl/lr_cmd_if.sv]
interface lr_cmd_if
	import lr_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   command;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;

	modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
	modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

[hw/rtl/lr_pix_if.sv]
interface lr_pix_if
	import lr_pkg::*;
();
	logic valid;
	logic ready;
	pix_t pixel_x;
	pix_t pixel_y;
	logic last;

	modport source (output valid, pixel_x, pixel_y, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

[hw/rtl/lr_setup.sv]
module lr_setup
	import lr_pkg::*;
(
	input  coord_t      x_start,
	input  coord_t      y_start,
	input  coord_t      x_end,
	input  coord_t      y_end,
	output line_state_t line_init
);

	diff_t dx, dy, adx, ady, sdx, sdy;
	dec_t  wdx, wdy;
	logic  neg, steep, swap;

	always_comb begin
		dx = diff_t'(x_end) - diff_t'(x_start);
		dy = diff_t'(y_end) - diff_t'(y_start);

		// Classify slope; zero run or rise counts as positive
		neg   = (dx[DIFF_BITS-1] && !dy[DIFF_BITS-1] && (dy != '0)) ||
		        (dy[DIFF_BITS-1] && !dx[DIFF_BITS-1] && (dx != '0));
		adx   = dx[DIFF_BITS-1] ? -dx : dx;
		ady   = dy[DIFF_BITS-1] ? -dy : dy;
		steep = ady > adx;

		// Pick the endpoint to start from
		if (!neg) begin
			swap = dx[DIFF_BITS-1] || dy[DIFF_BITS-1];
		end else if (!steep) begin
			swap = dx[DIFF_BITS-1];
		end else begin
			swap = !dy[DIFF_BITS-1] && (dy != '0);
		end

		sdx = swap ? -dx : dx;
		sdy = swap ? -dy : dy;
		wdx = dec_t'(sdx);
		wdy = dec_t'(sdy);

		line_init.cur_x = swap ? x_end : x_start;
		line_init.cur_y = swap ? y_end : y_start;

		// Decision term and increments per walking direction
		if (!neg && !steep) begin
			line_init.mode      = MODE_SHALLOW_POS;
			line_init.stop      = swap ? x_start : x_end;
			line_init.decision  = (wdy <<< 1) - wdx;
			line_init.incr_keep = wdy <<< 1;
			line_init.incr_diag = (wdy - wdx) <<< 1;
		end else if (!neg) begin
			line_init.mode      = MODE_STEEP_POS;
			line_init.stop      = swap ? y_start : y_end;
			line_init.decision  = (wdx <<< 1) - wdy;
			line_init.incr_keep = wdx <<< 1;
			line_init.incr_diag = (wdx - wdy) <<< 1;
		end else if (steep) begin
			line_init.mode      = MODE_STEEP_NEG;
			line_init.stop      = swap ? y_start : y_end;
			line_init.decision  = (wdx <<< 1) + wdy;
			line_init.incr_keep = wdx <<< 1;
			line_init.incr_diag = (wdx + wdy) <<< 1;
		end else begin
			line_init.mode      = MODE_SHALLOW_NEG;
			line_init.stop      = swap ? x_start : x_end;
			line_init.decision  = (wdy <<< 1) + wdx;
			line_init.incr_keep = wdy <<< 1;
			line_init.incr_diag = (wdy + wdx) <<< 1;
		end
	end

endmodule

[hw/rtl/lr_step.sv]
module lr_step
	import lr_pkg::*;
(
	input  line_state_t line_cur,
	output line_state_t line_next
);

	localparam coord_t COORD_ONE = coord_t'(1);

	logic dec_neg;

	always_comb begin
		line_next = line_cur;
		dec_neg   = line_cur.decision[DEC_BITS-1];

		// Advance one pixel along the major axis
		unique case (line_cur.mode)
			MODE_SHALLOW_POS: begin
				if (dec_neg) begin
					line_next.decision = line_cur.decision + line_cur.incr_keep;
				end else begin
					line_next.decision = line_cur.decision + line_cur.incr_diag;
					line_next.cur_y    = line_cur.cur_y + COORD_ONE;
				end
				line_next.cur_x = line_cur.cur_x + COORD_ONE;
			end
			MODE_STEEP_POS: begin
				if (dec_neg) begin
					line_next.decision = line_cur.decision + line_cur.incr_keep;
				end else begin
					line_next.decision = line_cur.decision + line_cur.incr_diag;
					line_next.cur_x    = line_cur.cur_x + COORD_ONE;
				end
				line_next.cur_y = line_cur.cur_y + COORD_ONE;
			end
			MODE_STEEP_NEG: begin
				if (dec_neg) begin
					line_next.decision = line_cur.decision + line_cur.incr_keep;
				end else begin
					line_next.decision = line_cur.decision + line_cur.incr_diag;
					line_next.cur_x    = line_cur.cur_x + COORD_ONE;
				end
				line_next.cur_y = line_cur.cur_y - COORD_ONE;
			end
			MODE_SHALLOW_NEG: begin
				// zero decision goes east here
				if (dec_neg) begin
					line_next.decision = line_cur.decision + line_cur.incr_diag;
					line_next.cur_y    = line_cur.cur_y - COORD_ONE;
				end else begin
					line_next.decision = line_cur.decision + line_cur.incr_keep;
				end
				line_next.cur_x = line_cur.cur_x + COORD_ONE;
			end
			default: begin
				line_next = line_cur;
			end
		endcase
	end

endmodule

[hw/rtl/line_rasterizer_unit.sv]
// Channel  Dir  Payload                                  Handshake
// cmd      in   command, x_start, y_start, x_end, y_end  valid/ready
// pix      out  pixel_x, pixel_y, last                   valid/ready
//
// One command word is taken per cycle unless a stalled pixel word holds the flow; a
// command word goes from the command register to the pixel register. The rate is set by
// the combinational decision/coordinate update between the command register and the pixel register.
// Reset restores the origin registers and drops any active line.
// A stalled pixel word holds; the command register still fills behind it.
module line_rasterizer_unit
	import lr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  origin_t  cfg_data
);

	logic        valid_s1;
	logic        command_s1;
	coord_t      x_start_s1, y_start_s1, x_end_s1, y_end_s1;

	origin_t     origin_x_q, origin_y_q;
	logic        active_q;
	line_state_t line_q;

	logic        out_valid_q;
	pix_t        pixel_x_q, pixel_y_q;
	logic        last_q;

	line_state_t line_init, line_stepped, line_next;
	logic        advance, is_start, emit, next_last;

	lr_setup u_setup (
		.x_start   (x_start_s1),
		.y_start   (y_start_s1),
		.x_end     (x_end_s1),
		.y_end     (y_end_s1),
		.line_init (line_init)
	);

	lr_step u_step (
		.line_cur  (line_q),
		.line_next (line_stepped)
	);

	// Move the held command forward when the pixel register is free
	always_comb begin
		advance   = valid_s1 && (!out_valid_q || pix.ready);
		is_start  = (command_s1 == CMD_START);
		emit      = is_start || active_q;
		line_next = is_start ? line_init : line_stepped;
		next_last = at_end(line_next);
	end

	assign cmd.ready   = !valid_s1 || advance;
	assign pix.valid   = out_valid_q;
	assign pix.pixel_x = pixel_x_q;
	assign pix.pixel_y = pixel_y_q;
	assign pix.last    = last_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			origin_x_q  <= ORIGIN_X_RESET;
			origin_y_q  <= ORIGIN_Y_RESET;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				out_valid_q <= emit;
				if (emit) begin
					active_q <= !next_last;
				end
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ORIGIN_X: origin_x_q <= cfg_data;
					CFG_ORIGIN_Y: origin_y_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Payload: command register, line state and pixel word
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1 <= cmd.command;
			x_start_s1 <= cmd.x_start;
			y_start_s1 <= cmd.y_start;
			x_end_s1   <= cmd.x_end;
			y_end_s1   <= cmd.y_end;
		end
		if (advance && emit) begin
			line_q    <= line_next;
			pixel_x_q <= to_screen(line_next.cur_x, origin_x_q);
			pixel_y_q <= to_screen(line_next.cur_y, origin_y_q);
			last_q    <= next_last;
		end
	end

endmodule

[hw/rtl/lr_checker.sv]
`include "line_rasterizer_unit_macros.svh"

module lr_checker
	import lr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pix_t pixel_x,
	input pix_t pixel_y,
	input logic last
);

	// A stalled pixel word holds
	`LR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

	// An empty pixel register never blocks the command side
	`LR_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A fresh pixel word follows a command word taken earlier
	`LR_ASSERT_IMPL(a_out_from_cmd, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (pix.valid),
	.out_ready (pix.ready),
	.pixel_x   (pix.pixel_x),
	.pixel_y   (pix.pixel_y),
	.last      (pix.last)
);

[verif/line_rasterizer_unit_tb.sv]
module line_rasterizer_unit_tb
	import lr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_PIXELS = 150;
	localparam int NUM_PHASES = 8;
	localparam int PLAN_ROWS = 26;

	typedef struct packed {
		pix_t x;
		pix_t y;
		logic last;
	} pixel_t;

	// One directed command word; the pixel is typed in where fixed is set
	typedef struct {
		logic   command;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
		bit     fixed;
		bit     emits;
		pix_t   ex;
		pix_t   ey;
		logic   elast;
	} plan_row_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	origin_t  cfg_data;

	lr_cmd_if cmd_ch();
	lr_pix_if pix_ch();

	line_rasterizer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.pix       (pix_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the walker state and the origin registers
	coord_t  cur_x, cur_y, stop;
	dec_t    decision, keep, diag;
	mode_t   mode;
	bit      active;
	origin_t org_x, org_y;

	pixel_t pixel_q[$];
	int     fails;
	int     drawn;
	int     cycles;
	bit     calm;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{CMD_STEP,  0, 0, 0, 0,                     1, 0, 0, 0, 0},
		'{CMD_START, 0, 0, 0, 0,                     1, 1, 320, 240, 1},
		'{CMD_START, -2048, -2048, -2048, -2048,     1, 1, -1728, -1808, 1},
		'{CMD_START, 2047, 2047, 2047, 2047,         1, 1, 2367, 2287, 1},
		'{CMD_START, 0, 0, 3, 1,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  -1, -1, -1, -1,                 0, 0, 0, 0, 0},
		'{CMD_STEP,  2047, -2048, 2047, -2048,       0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  -1, -1, -1, -1,                 1, 0, 0, 0, 0},
		'{CMD_START, 0, 0, 1, 3,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_START, 0, 0, 1, -3,                    0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_START, 0, 0, 4, -2,                    0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_START, -2048, 2047, 2047, -2048,       0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_START, 5, -7, -5, 7,                   0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0},
		'{CMD_START, 3, 3, -3, 3,                    0, 0, 0, 0, 0},
		'{CMD_STEP,  0, 0, 0, 0,                     0, 0, 0, 0, 0}
	};

	// Pick an idle stretch: mostly none, sometimes short, rarely long
	function automatic int pause_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Advance the shadow walker by one command word and form its pixel
	task automatic trace_pixel(input logic c, input coord_t xs, ys, xe, ye,
			output bit emits, output pixel_t p);
		int xa, ya, xb, yb, dx, dy, t, adx, ady;
		bit neg, steep, swap;
		emits = 1'b0;
		p = '0;
		if (c == CMD_START) begin
			xa = xs;
			ya = ys;
			xb = xe;
			yb = ye;
			dx = xb - xa;
			dy = yb - ya;
			neg = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			steep = ady > adx;
			// order endpoints so the major coordinate walks the right way
			if (!neg)
				swap = dx < 0 || dy < 0;
			else if (!steep)
				swap = dx < 0;
			else
				swap = dy > 0;
			if (swap) begin
				t = xa; xa = xb; xb = t;
				t = ya; ya = yb; yb = t;
				dx = -dx;
				dy = -dy;
			end
			cur_x = coord_t'(xa);
			cur_y = coord_t'(ya);
			if (!neg && !steep) begin
				mode = MODE_SHALLOW_POS;
				stop = coord_t'(xb);
				decision = dec_t'(2 * dy - dx);
				keep = dec_t'(2 * dy);
				diag = dec_t'(2 * (dy - dx));
			end else if (!neg) begin
				mode = MODE_STEEP_POS;
				stop = coord_t'(yb);
				decision = dec_t'(2 * dx - dy);
				keep = dec_t'(2 * dx);
				diag = dec_t'(2 * (dx - dy));
			end else if (steep) begin
				mode = MODE_STEEP_NEG;
				stop = coord_t'(yb);
				decision = dec_t'(2 * dx + dy);
				keep = dec_t'(2 * dx);
				diag = dec_t'(2 * (dx + dy));
			end else begin
				mode = MODE_SHALLOW_NEG;
				stop = coord_t'(xb);
				decision = dec_t'(2 * dy + dx);
				keep = dec_t'(2 * dy);
				diag = dec_t'(2 * (dy + dx));
			end
		end else begin
			// drop steps with no line in progress
			if (!active)
				return;
			case (mode)
				MODE_SHALLOW_POS: begin
					if (decision < 0)
						decision += keep;
					else begin
						decision += diag;
						cur_y++;
					end
					cur_x++;
				end
				MODE_STEEP_POS: begin
					if (decision < 0)
						decision += keep;
					else begin
						decision += diag;
						cur_x++;
					end
					cur_y++;
				end
				MODE_STEEP_NEG: begin
					if (decision < 0)
						decision += keep;
					else begin
						decision += diag;
						cur_x++;
					end
					cur_y--;
				end
				default: begin
					// zero decision goes east on the shallow falling line
					if (decision < 0) begin
						decision += diag;
						cur_y--;
					end else
						decision += keep;
					cur_x++;
				end
			endcase
		end
		if (mode == MODE_SHALLOW_POS || mode == MODE_SHALLOW_NEG)
			active = cur_x != stop;
		else
			active = cur_y != stop;
		emits = 1'b1;
		p.x = pix_t'(int'(cur_x) + int'(org_x));
		p.y = pix_t'(int'(cur_y) + int'(org_y));
		p.last = !active;
	endtask

	// Present one command word, hold it until taken, then predict
	task automatic put_word(input logic c, input coord_t xs, ys, xe, ye,
			output bit emits, output pixel_t p);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.x_start <= xs;
		cmd_ch.y_start <= ys;
		cmd_ch.x_end <= xe;
		cmd_ch.y_end <= ye;
		do
			@(posedge clk);
		while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
		trace_pixel(c, xs, ys, xe, ye, emits, p);
		if ($urandom_range(0, 149) == 0)
			calm = !calm;
	endtask

	task automatic send_word(input logic c, input coord_t xs, ys, xe, ye);
		bit     emits;
		pixel_t p;
		put_word(c, xs, ys, xe, ye, emits, p);
		if (emits) begin
			pixel_q.push_back(p);
			drawn++;
		end
	endtask

	// Start a random line, then walk it fully, past its end, or partway
	task automatic draw_random_line();
		coord_t xs, ys, xe, ye;
		int dxi, dyi, major, nsteps, r, i;
		if ($urandom_range(0, 19) == 0)
			send_word(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
		xs = coord_t'($urandom);
		ys = coord_t'($urandom);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			xe = coord_t'($urandom);
			ye = coord_t'($urandom);
		end else begin
			dxi = int'($urandom_range(0, 48)) - 24;
			dyi = int'($urandom_range(0, 48)) - 24;
			if (r < 18)
				dyi = 0;
			else if (r < 28)
				dxi = 0;
			else if (r < 36)
				dyi = ($urandom_range(0, 1) == 1) ? dxi : -dxi;
			xe = coord_t'(int'(xs) + dxi);
			ye = coord_t'(int'(ys) + dyi);
		end
		dxi = int'(xe) - int'(xs);
		dyi = int'(ye) - int'(ys);
		if (dxi < 0)
			dxi = -dxi;
		if (dyi < 0)
			dyi = -dyi;
		major = (dxi > dyi) ? dxi : dyi;
		send_word(CMD_START, xs, ys, xe, ye);
		r = $urandom_range(0, 99);
		if (r < 75)
			nsteps = major;
		else if (r < 90)
			nsteps = major + $urandom_range(1, 3);
		else
			nsteps = $urandom_range(0, major);
		if (nsteps > 200)
			nsteps = $urandom_range(0, 200);
		for (i = 0; i < nsteps; i++)
			send_word(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
	endtask

	// Idle the command side and wait out every pixel still in flight
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_origin(input origin_t ox, input origin_t oy);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data <= ox;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_Y;
		cfg_data <= oy;
		@(posedge clk);
		cfg_we <= 1'b0;
		org_x = ox;
		org_y = oy;
	endtask

	// Compare a taken pixel word with the oldest expected one
	task automatic check_pixel();
		pixel_t e;
		if (pixel_q.size() == 0) begin
			$error("unexpected pixel word: pixel_x %0d pixel_y %0d last %0b",
				pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last);
			fails++;
			return;
		end
		e = pixel_q.pop_front();
		if (pix_ch.pixel_x !== e.x) begin
			$error("pixel_x: expected %0d, actual %0d", e.x, pix_ch.pixel_x);
			fails++;
		end
		if (pix_ch.pixel_y !== e.y) begin
			$error("pixel_y: expected %0d, actual %0d", e.y, pix_ch.pixel_y);
			fails++;
		end
		if (pix_ch.last !== e.last) begin
			$error("last: expected %0b, actual %0b", e.last, pix_ch.last);
			fails++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL line_rasterizer_unit");
		$finish;
	end

	// Take pixel words, stalling at random
	initial begin
		int hold;
		hold = 0;
		pix_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
				check_pixel();
			if (hold > 0) begin
				pix_ch.ready <= 1'b0;
				hold--;
			end else begin
				pix_ch.ready <= 1'b1;
				hold = pause_len();
			end
		end
	end

	initial begin
		bit     emits;
		pixel_t p;
		int     ph, target;
		origin_t ox, oy;
		fails = 0;
		drawn = 0;
		calm = 1'b0;
		cur_x = '0;
		cur_y = '0;
		stop = '0;
		decision = '0;
		keep = '0;
		diag = '0;
		mode = MODE_SHALLOW_POS;
		active = 1'b0;
		org_x = ORIGIN_X_RESET;
		org_y = ORIGIN_Y_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_START;
		cmd_ch.x_start <= '0;
		cmd_ch.y_start <= '0;
		cmd_ch.x_end <= '0;
		cmd_ch.y_end <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset origin
		for (int k = 0; k < PLAN_ROWS; k++) begin
			put_word(plan[k].command, plan[k].xs, plan[k].ys, plan[k].xe, plan[k].ye,
				emits, p);
			if (plan[k].fixed) begin
				if (plan[k].emits) begin
					p.x = plan[k].ex;
					p.y = plan[k].ey;
					p.last = plan[k].elast;
					pixel_q.push_back(p);
				end
			end else if (emits)
				pixel_q.push_back(p);
		end

		// Random lines, one origin setting per phase
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin ox = '1; oy = '1; end
				1: begin ox = '0; oy = '0; end
				2: begin ox = '0; oy = '1; end
				3: begin ox = '1; oy = '0; end
				default: begin
					ox = origin_t'($urandom);
					oy = origin_t'($urandom);
				end
			endcase
			load_origin(ox, oy);
			target = drawn + PHASE_PIXELS;
			while (drawn < target)
				draw_random_line();
		end

		settle();
		if (fails == 0)
			$display("PASS line_rasterizer_unit");
		else
			$display("FAIL line_rasterizer_unit");
		$finish;
	end

endmodule
